// ===== hdl/ple_pkg.sv =====
// Package for the positional list engine.
// Holds the channel field widths, the operation codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

  // Field widths of the input and result channels.
  localparam int unsigned FuncW  = 2;
  localparam int unsigned PosW   = 5;
  localparam int unsigned ItemW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned ValueW = 32;

  // Operation codes carried in the func field.
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOVE,
    ST_FETCH,
    ST_DONE
  } state_e;

endpackage

// ===== hdl/ple_if.sv =====
// Valid/ready channel interfaces for the positional list engine.
// Depends on ple_pkg for the field widths.
`timescale 1ns / 1ps

// Operation channel: one item is one list operation.
interface ple_in_if import ple_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [PosW-1:0]   position;
  logic [ItemW-1:0]  item;

  modport source (output valid, func, position, item, input ready);
  modport sink   (input valid, func, position, item, output ready);
endinterface

// Result channel: one item per operation.
interface ple_out_if import ple_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ValueW-1:0] read_value;
  logic [CountW-1:0] count;
  logic              empty_res;

  modport source (output valid, ok, read_value, count, empty_res, input ready);
  modport sink   (input valid, ok, read_value, count, empty_res, output ready);
endinterface

// ===== hdl/ple_step_unit.sv =====
// Shared index step unit of the positional list engine.
// Steps the shift index up or down by one and tells whether another move is due.
// No dependencies.
`timescale 1ns / 1ps

module ple_step_unit #(
  parameter int unsigned W = 9
) (
  input  logic [W-1:0] idx_i,
  input  logic [W-1:0] bound_i,
  input  logic         up_i,
  output logic [W-1:0] next_o,
  output logic         more_o
);

  // Moving up (remove) continues while the next index stays below the bound;
  // moving down (insert) continues while the index is above the bound.
  always_comb begin
    if (up_i) begin
      next_o = idx_i + W'(1);
      more_o = (next_o < bound_i);
    end else begin
      next_o = idx_i - W'(1);
      more_o = (idx_i > bound_i);
    end
  end

endmodule

// ===== hdl/ple_mem.sv =====
// Element storage of the positional list engine.
// One write port and one read port with registered read data. No dependencies.
`timescale 1ns / 1ps

module ple_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with the data registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Positional list engine: a bounded ordered list of CAPACITY elements that takes one
// operation item at a time (insert at an index, remove at an index, or read at an index)
// and returns one result item with a success flag, the read data, the element count and
// an empty flag. The elements live in a single-port-read, single-port-write memory, so
// each element that has to shift is first read (ST_CHECK) and then written one place over
// (ST_MOVE). A finished result waits in an output register, so the next operation is taken
// while the previous result is still pending. Depends on ple_pkg, ple_if, ple_step_unit and
// ple_mem.
`timescale 1ns / 1ps

module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_in_if.sink    in_i,
  ple_out_if.source out_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  state_e                state_q, state_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [CMPW-1:0]       idx_q, idx_d;
  logic [CMPW-1:0]       pos_q, pos_d;
  logic [DATA_WIDTH-1:0] item_q, item_d;
  logic                  is_remove_q, is_remove_d;
  logic                  res_ok_q, res_ok_d;
  logic [ValueW-1:0]     res_val_q, res_val_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_ok_q, out_ok_d;
  logic [ValueW-1:0]     out_val_q, out_val_d;
  logic [CountW-1:0]     out_count_q, out_count_d;
  logic                  out_empty_q, out_empty_d;

  logic                  mem_wr_en, mem_rd_en;
  logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;

  logic [CMPW-1:0]       pos_ext, fill_ext, step_bound, step_next;
  logic                  step_more;

  assign pos_ext    = CMPW'(in_i.position);
  assign fill_ext   = CMPW'(fill_q);
  assign step_bound = is_remove_q ? fill_ext : pos_q;

  // Shared step unit that walks the shift index.
  ple_step_unit #(
    .W (CMPW)
  ) u_step (
    .idx_i   (idx_q),
    .bound_i (step_bound),
    .up_i    (is_remove_q),
    .next_o  (step_next),
    .more_o  (step_more)
  );

  // Element storage.
  ple_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Sequencer: next state, memory control and result capture.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    item_d      = item_q;
    is_remove_d = is_remove_q;
    res_ok_d    = res_ok_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_ok_d    = out_ok_q;
    out_val_d   = out_val_q;
    out_count_d = out_count_q;
    out_empty_d = out_empty_q;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_q[AW-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = step_next[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          pos_d       = pos_ext;
          item_d      = DATA_WIDTH'(in_i.item);
          res_ok_d    = 1'b0;
          res_val_d   = '0;
          is_remove_d = 1'b0;
          state_d     = ST_DONE;
          case (func_e'(in_i.func))
            FUNC_INSERT: begin
              if ((pos_ext <= fill_ext) && (fill_ext < CMPW'(CAPACITY))) begin
                res_ok_d = 1'b1;
                idx_d    = fill_ext;
                state_d  = ST_CHECK;
              end
            end
            FUNC_REMOVE: begin
              if (pos_ext < fill_ext) begin
                res_ok_d    = 1'b1;
                is_remove_d = 1'b1;
                idx_d       = pos_ext;
                state_d     = ST_CHECK;
              end
            end
            FUNC_READ: begin
              if (pos_ext < fill_ext) begin
                res_ok_d    = 1'b1;
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_ext[AW-1:0];
                state_d     = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      // Either fetch the next element to shift, or finish the operation.
      ST_CHECK: begin
        if (step_more) begin
          mem_rd_en = 1'b1;
          state_d   = ST_MOVE;
        end else begin
          if (is_remove_q) begin
            fill_d = fill_q - CW'(1);
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_data = item_q;
            fill_d      = fill_q + CW'(1);
          end
          state_d = ST_DONE;
        end
      end

      // Write the fetched element one place over.
      ST_MOVE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_q[AW-1:0];
        mem_wr_data = mem_rd_data;
        idx_d       = step_next;
        state_d     = ST_CHECK;
      end

      ST_FETCH: begin
        res_val_d = ValueW'(mem_rd_data);
        state_d   = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_val_d   = res_val_q;
          out_count_d = CountW'(fill_q);
          out_empty_d = (fill_q == '0);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    item_q      <= item_d;
    is_remove_q <= is_remove_d;
    res_ok_q    <= res_ok_d;
    res_val_q   <= res_val_d;
    out_ok_q    <= out_ok_d;
    out_val_q   <= out_val_d;
    out_count_q <= out_count_d;
    out_empty_q <= out_empty_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.ok         = out_ok_q;
  assign out_o.read_value = out_val_q;
  assign out_o.count      = out_count_q;
  assign out_o.empty_res  = out_empty_q;

  // The element count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // The count only changes at the end of an insert or a remove.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ($past(state_q) == ST_CHECK))
    else $error("element count changed outside an operation end");

  // A new result only appears after the sequencer has finished an operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result shown without a finished operation");

  // A rejected operation never carries read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_val_q == '0))
    else $error("rejected operation with nonzero read data");

endmodule
